// ===== rtl/core/sorted_slot_list_unit_assert.svh =====
// Assertion macros used by sorted_slot_list_unit. All of them sample on i_clk and
// are disabled while i_rst_n is low.
`ifndef SORTED_SLOT_LIST_UNIT_ASSERT_SVH
`define SORTED_SLOT_LIST_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge.
`define SSL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent this cycle implies consequent in the next cycle.
`define SSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define SSL_ASSERT_ALWAYS(lbl, cond, msg)
`define SSL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/ssl_pkg.sv =====
`default_nettype none

package ssl_pkg;

    localparam int SSL_SLOTS_DEF = 32;

    localparam logic [7:0] NO_LINK       = 8'hFF;
    localparam logic [7:0] EMPTY_MARK    = 8'hFF;
    localparam logic [7:0] MAX_VALUE_RST = 8'd100;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SLOT_RANGE  = 3'd1,
        ST_SLOT_BUSY   = 3'd2,
        ST_VALUE_RANGE = 3'd3,
        ST_DUPLICATE   = 3'd4,
        ST_NOT_FOUND   = 3'd5
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/core/ssl_ram.sv =====
`default_nettype none

module ssl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_slot_list_unit.sv =====
// An item rejected by its range or occupancy checks goes straight to S_FIN; otherwise the
//   chain walk compares slots in order until it finds the position or the end of the chain.
//   A chain step is a registered RAM read (S_RD), then a compare (S_CMP).
// Throughput: one item at a time; the next item is taken the cycle after the result is
//   loaded into the output register, later while a held result is stalled.
// Reset (synchronous, i_rst_n low): occupied bits and head cleared, max_value 100, no result.
`default_nettype none
`include "sorted_slot_list_unit_assert.svh"

module sorted_slot_list_unit
    import ssl_pkg::*;
#(
    parameter int SLOTS = SSL_SLOTS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    // item in
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_func,
    input  wire logic [7:0] i_slot,
    input  wire logic [7:0] i_value,
    // result out
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic      [2:0] o_status,
    output logic      [7:0] o_head_slot
);

    localparam int         AW      = $clog2(SLOTS);
    localparam logic [7:0] SLOTS_B = 8'(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_WR1,
        S_WR2,
        S_FIN
    } t_state;

    t_state           r_state;
    logic [7:0]       r_max_value;
    logic [SLOTS-1:0] r_occ;
    logic [7:0]       r_head;
    logic             r_func;
    logic [7:0]       r_slot;
    logic [7:0]       r_value;
    logic [7:0]       r_cur;
    logic [7:0]       r_prev;
    t_status          r_status;
    logic             r_ovalid;
    t_status          r_ostatus;
    logic [7:0]       r_ohead;

    logic             accept;
    logic [7:0]       val_rd;
    logic [7:0]       lnk_rd;
    logic             val_we;
    logic             lnk_we;
    logic [AW-1:0]    lnk_waddr;
    logic [7:0]       lnk_wdata;

    assign accept      = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_head_slot = r_ohead;

    // RAM write control
    always_comb begin
        val_we    = (r_state == S_WR1);
        lnk_we    = 1'b0;
        lnk_waddr = r_slot[AW-1:0];
        lnk_wdata = r_cur;
        unique case (r_state)
            S_WR1: begin
                lnk_we = 1'b1;
            end
            S_WR2: begin
                lnk_we    = 1'b1;
                lnk_waddr = r_prev[AW-1:0];
                lnk_wdata = r_slot;
            end
            S_CMP: begin
                // unlink on delete hit when there is a predecessor
                lnk_we    = (r_func == FUNC_DELETE) && (val_rd == r_value)
                            && (r_prev != NO_LINK);
                lnk_waddr = r_prev[AW-1:0];
                lnk_wdata = lnk_rd;
            end
            default: begin
            end
        endcase
    end

    ssl_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_slot[AW-1:0]),
        .i_wdata (r_value),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata (val_rd)
    );

    ssl_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_lnk_ram (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_waddr (lnk_waddr),
        .i_wdata (lnk_wdata),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata (lnk_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_value <= MAX_VALUE_RST;
            r_occ       <= '0;
            r_head      <= NO_LINK;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_value <= i_cfg_wdata;
            end
            // S_FIN reloads the output register itself
            if (r_ovalid && !i_stall && (r_state != S_FIN)) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func  <= i_func;
                        r_slot  <= i_slot;
                        r_value <= i_value;
                        r_cur   <= r_head;
                        r_prev  <= NO_LINK;
                        if (i_func == FUNC_INSERT && i_slot >= SLOTS_B) begin
                            r_status <= ST_SLOT_RANGE;
                            r_state  <= S_FIN;
                        end else if (i_func == FUNC_INSERT && r_occ[i_slot[AW-1:0]]) begin
                            r_status <= ST_SLOT_BUSY;
                            r_state  <= S_FIN;
                        end else if (i_value > r_max_value || i_value == EMPTY_MARK) begin
                            r_status <= ST_VALUE_RANGE;
                            r_state  <= S_FIN;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (r_cur == NO_LINK) begin
                        // end of chain
                        if (r_func == FUNC_INSERT) begin
                            r_state <= S_WR1;
                        end else begin
                            r_status <= ST_NOT_FOUND;
                            r_state  <= S_FIN;
                        end
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (val_rd < r_value) begin
                        r_prev  <= r_cur;
                        r_cur   <= lnk_rd;
                        r_state <= S_RD;
                    end else if (val_rd == r_value) begin
                        if (r_func == FUNC_INSERT) begin
                            r_status <= ST_DUPLICATE;
                        end else begin
                            r_occ[r_cur[AW-1:0]] <= 1'b0;
                            if (r_prev == NO_LINK) begin
                                r_head <= lnk_rd;
                            end
                        end
                        r_state <= S_FIN;
                    end else begin
                        if (r_func == FUNC_INSERT) begin
                            r_state <= S_WR1;
                        end else begin
                            r_status <= ST_NOT_FOUND;
                            r_state  <= S_FIN;
                        end
                    end
                end
                S_WR1: begin
                    // new slot links to r_cur; predecessor or head points at it
                    r_occ[r_slot[AW-1:0]] <= 1'b1;
                    if (r_prev == NO_LINK) begin
                        r_head  <= r_slot;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_WR2;
                    end
                end
                S_WR2: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_status;
                        r_ohead   <= r_head;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SSL_ASSERT_NEXT(a_busy_after_accept, accept, o_stall, "block not busy after accept")
    `SSL_ASSERT_ALWAYS(a_head_range, (r_head == NO_LINK) || (r_head < SLOTS_B), "head out of range")
    `SSL_ASSERT_ALWAYS(a_head_empty, (r_head == NO_LINK) == (r_occ == '0), "head and occupancy disagree")
    `SSL_ASSERT_NEXT(a_out_drain, o_valid && !i_stall && (r_state != S_FIN), !o_valid, "result repeated")

endmodule

`default_nettype wire
